[design/kmm_pkg.sv]
// Shared types, constants and helpers for the keyed min/max merge table.
// No dependencies; imported by kmm_merge_rule and keyed_min_max_merge_table.
`default_nettype none
package kmm_pkg;

   localparam int TABLE_DEPTH     = 64;
   localparam int SLOT_WIDTH      = $clog2(TABLE_DEPTH);
   localparam int TOTAL_WIDTH     = 7;
   localparam int KEY_WIDTH       = 64;
   localparam int SCORE_WIDTH     = 32;
   localparam int MODE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_MODE = 2'd1;

   localparam logic [MODE_WIDTH-1:0] MIN_MODE_RESET = 8'd5;
   localparam logic [MODE_WIDTH-1:0] MAX_MODE_RESET = 8'd7;

   typedef enum logic [1:0] {
      FUNC_MERGE = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_IMPROVED  = 3'd0,
      STATUS_UNCHANGED = 3'd1,
      STATUS_APPENDED  = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_POPPED    = 3'd4,
      STATUS_POP_EMPTY = 3'd5,
      STATUS_CLEARED   = 3'd6,
      STATUS_BAD_MODE  = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SEARCH,
      STATE_POP,
      STATE_RESP
   } state_type;

   typedef struct packed {
      func_type                       func;
      logic [KEY_WIDTH-1:0]           key;
      logic signed [SCORE_WIDTH-1:0]  score;
      logic [MODE_WIDTH-1:0]          mode;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic [KEY_WIDTH-1:0]           entry_key;
      logic signed [SCORE_WIDTH-1:0]  entry_score;
      logic [MODE_WIDTH-1:0]          entry_mode;
      logic [TOTAL_WIDTH-1:0]         entry_total;
   } rsp_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]           key;
      logic signed [SCORE_WIDTH-1:0]  score;
      logic [MODE_WIDTH-1:0]          mode;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic       replace;
   } merge_result_type;

   // ring slot addition, both operands below TABLE_DEPTH
   function automatic logic [SLOT_WIDTH-1:0] slot_add(input logic [SLOT_WIDTH-1:0] base,
                                                      input logic [SLOT_WIDTH-1:0] off);
      logic [SLOT_WIDTH:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (SLOT_WIDTH+1)'(TABLE_DEPTH)) begin
         sum = sum - (SLOT_WIDTH+1)'(TABLE_DEPTH);
      end
      return sum[SLOT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

[design/kmm_merge_rule.sv]
// Min/max keep rule for a merge hit: signed compare and status select.
// Depends on kmm_pkg.
`default_nettype none
module kmm_merge_rule (
   input  wire logic [kmm_pkg::MODE_WIDTH-1:0]         mode,
   input  wire logic [kmm_pkg::MODE_WIDTH-1:0]         min_code,
   input  wire logic [kmm_pkg::MODE_WIDTH-1:0]         max_code,
   input  wire logic signed [kmm_pkg::SCORE_WIDTH-1:0] offered,
   input  wire logic signed [kmm_pkg::SCORE_WIDTH-1:0] stored,
   output kmm_pkg::merge_result_type                   result
);
   import kmm_pkg::*;

   logic lower;
   logic higher;

   assign lower  = offered < stored;
   assign higher = stored < offered;

   // min code checked first so it wins when both codes match
   always_comb begin
      result.replace = 1'b0;
      result.status  = STATUS_BAD_MODE;
      if (mode == min_code) begin
         result.replace = lower;
         result.status  = lower ? STATUS_IMPROVED : STATUS_UNCHANGED;
      end else if (mode == max_code) begin
         result.replace = higher;
         result.status  = higher ? STATUS_IMPROVED : STATUS_UNCHANGED;
      end
   end

endmodule
`default_nettype wire

[design/keyed_min_max_merge_table.sv]
// Keyed min/max merge table: ring of records in one synchronous memory, linear key search.
// A merge hit ends the search early; the response waits on rsp_ready.
// One transaction in flight; search reads one slot per cycle.
// Throughput is set by the single memory read port.
// Reset (synchronous, active high) empties the table and restores mode codes 5 and 7;
// memory contents are not cleared and need no clearing pass.
`default_nettype none
module keyed_min_max_merge_table (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire kmm_pkg::req_type                       req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output kmm_pkg::rsp_type                            rsp_data,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [kmm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [kmm_pkg::MODE_WIDTH-1:0]         csr_data
);
   import kmm_pkg::*;

   entry_type table_mem [TABLE_DEPTH];

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [TOTAL_WIDTH-1:0]  idx_ff, idx_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [SLOT_WIDTH-1:0]   cmp_slot_ff, cmp_slot_in;
   logic [SLOT_WIDTH-1:0]   oldest_ff, oldest_in;
   logic [TOTAL_WIDTH-1:0]  total_ff, total_in;
   logic [MODE_WIDTH-1:0]   min_code_ff, min_code_in;
   logic [MODE_WIDTH-1:0]   max_code_ff, max_code_in;
   rsp_type                 res_ff, res_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   entry_type               rd_entry_ff;

   logic                    mem_re;
   logic [SLOT_WIDTH-1:0]   mem_raddr;
   logic                    mem_we;
   logic [SLOT_WIDTH-1:0]   mem_waddr;
   entry_type               mem_wdata;

   logic                    hit;
   logic                    more_reads;
   logic                    table_full;
   logic                    rsp_free;
   merge_result_type        rule;

   assign hit        = cmp_valid_ff && (rd_entry_ff.key == req_ff.key);
   assign more_reads = idx_ff < total_ff;
   assign table_full = total_ff == TOTAL_WIDTH'(TABLE_DEPTH);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign req_ready = state_ff == STATE_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   kmm_merge_rule u_rule (
      .mode     (req_ff.mode),
      .min_code (min_code_ff),
      .max_code (max_code_ff),
      .offered  (req_ff.score),
      .stored   (rd_entry_ff.score),
      .result   (rule)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FUNC_MERGE: state_in = STATE_SEARCH;
                  FUNC_POP:   state_in = (total_ff == '0) ? STATE_RESP : STATE_POP;
                  default:    state_in = STATE_RESP;
               endcase
            end
         end
         STATE_SEARCH: begin
            if (hit) begin
               state_in = STATE_RESP;
            end else if (!more_reads && !cmp_valid_ff) begin
               state_in = STATE_RESP;
            end
         end
         STATE_POP: state_in = STATE_RESP;
         STATE_RESP: begin
            if (rsp_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in       = req_ff;
      idx_in       = idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_slot_in  = cmp_slot_ff;
      oldest_in    = oldest_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_re       = 1'b0;
      mem_raddr    = oldest_ff;
      mem_we       = 1'b0;
      mem_waddr    = cmp_slot_ff;
      mem_wdata    = '{key: req_ff.key, score: req_ff.score, mode: req_ff.mode};

      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               idx_in       = '0;
               cmp_valid_in = 1'b0;
               mem_re       = 1'b1;   // oldest record, used by pop
               case (req_data.func)
                  FUNC_CLEAR: begin
                     oldest_in = '0;
                     total_in  = '0;
                     res_in    = '{STATUS_CLEARED, '0, '0, '0, '0};
                  end
                  FUNC_POP:   res_in = '{STATUS_POP_EMPTY, '0, '0, '0, total_ff};
                  default:    res_in = '{STATUS_UNCHANGED, '0, '0, '0, total_ff};
               endcase
            end
         end
         STATE_POP: begin
            oldest_in = slot_add(oldest_ff, SLOT_WIDTH'(1));
            total_in  = total_ff - TOTAL_WIDTH'(1);
            res_in    = '{STATUS_POPPED, rd_entry_ff.key, rd_entry_ff.score,
                          rd_entry_ff.mode, total_ff - TOTAL_WIDTH'(1)};
         end
         STATE_SEARCH: begin
            if (hit) begin
               mem_we    = rule.replace;
               mem_waddr = cmp_slot_ff;
               mem_wdata = '{key: rd_entry_ff.key, score: req_ff.score,
                             mode: rd_entry_ff.mode};
               res_in    = '{rule.status, rd_entry_ff.key,
                             rule.replace ? req_ff.score : rd_entry_ff.score,
                             rd_entry_ff.mode, total_ff};
            end else if (more_reads) begin
               // issue next slot while the previous read is compared
               mem_re       = 1'b1;
               mem_raddr    = slot_add(oldest_ff, idx_ff[SLOT_WIDTH-1:0]);
               cmp_slot_in  = mem_raddr;
               cmp_valid_in = 1'b1;
               idx_in       = idx_ff + TOTAL_WIDTH'(1);
            end else if (cmp_valid_ff) begin
               cmp_valid_in = 1'b0;
            end else if (table_full) begin
               res_in = '{STATUS_FULL, '0, '0, '0, total_ff};
            end else begin
               mem_we    = 1'b1;
               mem_waddr = slot_add(oldest_ff, total_ff[SLOT_WIDTH-1:0]);
               total_in  = total_ff + TOTAL_WIDTH'(1);
               res_in    = '{STATUS_APPENDED, req_ff.key, req_ff.score, req_ff.mode,
                             total_ff + TOTAL_WIDTH'(1)};
            end
         end
         STATE_RESP: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // configuration writes
   always_comb begin
      min_code_in = min_code_ff;
      max_code_in = max_code_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_MODE: min_code_in = csr_data;
            CSR_MAX_MODE: max_code_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         cmp_valid_ff <= 1'b0;
         oldest_ff    <= '0;
         total_ff     <= '0;
         min_code_ff  <= MIN_MODE_RESET;
         max_code_ff  <= MAX_MODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         oldest_ff    <= oldest_in;
         total_ff     <= total_in;
         min_code_ff  <= min_code_in;
         max_code_ff  <= max_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      cmp_slot_ff <= cmp_slot_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_entry_ff <= table_mem[mem_raddr];
      end
   end

endmodule
`default_nettype wire
